// ===== rtl/lrf_pkg.sv =====
// Package for the longest line run finder.
// Holds shared widths, register indexes, direction codes and the stage structs.
// No dependencies.
`default_nettype none
package lrf_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int HW_LIMIT     = 256;

  localparam int LEN_W   = 9;
  localparam int COORD_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

  localparam logic DIR_HORIZONTAL = 1'b0;
  localparam logic DIR_VERTICAL   = 1'b1;

  typedef struct packed {
    logic               px;
    logic               dir;
    logic [LEN_W-1:0]   hl;
    logic [LEN_W-1:0]   vl;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cand_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [COORD_W-1:0] sr;
    logic [COORD_W-1:0] sc;
    logic [COORD_W-1:0] er;
    logic [COORD_W-1:0] ec;
  } run_t;

endpackage
`default_nettype wire

// ===== rtl/lrf_col_mem.sv =====
// Column run length memory: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module lrf_col_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:DEPTH-1];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/lrf_best.sv =====
// Best run register with the compare that merges one candidate per pixel.
// Depends on lrf_pkg.
`default_nettype none
module lrf_best (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic          last,
  input  wire lrf_pkg::cand_t cand,
  output      lrf_pkg::run_t  merged
);
  import lrf_pkg::*;

  run_t best_r;
  run_t best_nxt;
  logic [LEN_W-1:0]   sc_h;
  logic [LEN_W-1:0]   sr_v;
  logic               take_v;

  always_comb begin
    sc_h = {1'b0, cand.col} + LEN_W'(1) - cand.hl;
    sr_v = {1'b0, cand.row} + LEN_W'(1) - cand.vl;
    take_v = (cand.vl > best_r.len) ||
             ((cand.vl == best_r.len) &&
              ((cand.col < best_r.sc) ||
               ((cand.col == best_r.sc) && (sr_v[COORD_W-1:0] < best_r.sr))));
    merged = best_r;
    if (cand.px) begin
      if (cand.dir == DIR_HORIZONTAL) begin
        if (cand.hl > best_r.len) begin
          merged.len = cand.hl;
          merged.sr  = cand.row;
          merged.sc  = sc_h[COORD_W-1:0];
          merged.er  = cand.row;
          merged.ec  = cand.col;
        end
      end else if (take_v) begin
        merged.len = cand.vl;
        merged.sr  = sr_v[COORD_W-1:0];
        merged.sc  = cand.col;
        merged.er  = cand.row;
        merged.ec  = cand.col;
      end
    end
    best_nxt = last ? '0 : merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (fire) begin
      best_r <= best_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/longest_line_run_finder_unit.sv =====
// Longest line run finder, top level: position counters, read stage, run update
// stage, column memory and result register. Depends on lrf_pkg, lrf_col_mem,
// lrf_best.
//
// Usage: configure direction, row_count and column_count on the cfg channel
// (always ready) while no image is in flight. Stream one pixel per transfer in
// row-major order on the in channel. After the last pixel of an image one
// result transfer appears on the out channel: found, run length and the first
// and last pixel of the longest run of ones.
// Throughput: one pixel per cycle while in_ready is high. Each pixel reads its
// column's run length from the column memory in the cycle it is accepted,
// updates it in the run update stage and writes it back; back-to-back pixels in
// the same column are forwarded. The result register and out_valid are loaded
// when the last pixel leaves the run update stage.
// Reset: counters, best run and out_valid are cleared, registers return to
// horizontal 256 x 256. The column memory is not cleared; row 0 writes it.
// Stall: a waiting result does not stop pixel input; only when the next
// image's last pixel reaches the update stage with the result still untaken
// does in_ready drop until out_ready is seen.
`default_nettype none
module longest_line_run_finder_unit #(
  parameter int MAX_ROWS = lrf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lrf_pkg::DEF_MAX_COLS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [lrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrf_pkg::LEN_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_pixel,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_found,
  output      logic [lrf_pkg::LEN_W-1:0]     out_run_length,
  output      logic [lrf_pkg::COORD_W-1:0]   out_start_row,
  output      logic [lrf_pkg::COORD_W-1:0]   out_start_col,
  output      logic [lrf_pkg::COORD_W-1:0]   out_end_row,
  output      logic [lrf_pkg::COORD_W-1:0]   out_end_col
);
  import lrf_pkg::*;

  localparam int ROW_LIM = (MAX_ROWS < HW_LIMIT) ? MAX_ROWS : HW_LIMIT;
  localparam int COL_LIM = (MAX_COLS < HW_LIMIT) ? MAX_COLS : HW_LIMIT;
  localparam int COL_AW  = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;

  logic               dir_r;
  logic [LEN_W-1:0]   row_cnt_cfg_r;
  logic [LEN_W-1:0]   col_cnt_cfg_r;

  logic [COORD_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COORD_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [LEN_W-1:0]   nr, nc;
  logic [COORD_W-1:0] r0, c0;
  logic [LEN_W-1:0]   c0_inc, r0_inc;
  logic               last0;
  logic               in_fire;

  logic               s1_valid_r;
  logic               s1_px_r;
  logic               s1_last_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [COORD_W-1:0] s1_col_r;
  logic               fwd_sel_r;
  logic [LEN_W-1:0]   fwd_val_r;
  logic               s1_fire;
  logic               stall;

  logic [LEN_W-1:0]   row_run_r;
  logic [LEN_W-1:0]   rd_data;
  logic [LEN_W-1:0]   prev_v;
  logic [LEN_W:0]     hl_sum, vl_sum;
  logic [LEN_W-1:0]   hl, vl;
  cand_t              cand;
  run_t               merged;

  logic               out_valid_r;
  run_t               out_run_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r         <= DIR_HORIZONTAL;
      row_cnt_cfg_r <= LEN_W'(HW_LIMIT);
      col_cnt_cfg_r <= LEN_W'(HW_LIMIT);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIRECTION:    dir_r         <= cfg_data[0];
        CFG_ROW_COUNT:    row_cnt_cfg_r <= cfg_data;
        CFG_COLUMN_COUNT: col_cnt_cfg_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // position stage
  always_comb begin
    nr = (row_cnt_cfg_r == '0) ? LEN_W'(1) :
         (row_cnt_cfg_r > LEN_W'(ROW_LIM)) ? LEN_W'(ROW_LIM) : row_cnt_cfg_r;
    nc = (col_cnt_cfg_r == '0) ? LEN_W'(1) :
         (col_cnt_cfg_r > LEN_W'(COL_LIM)) ? LEN_W'(COL_LIM) : col_cnt_cfg_r;
    r0 = ({1'b0, row_cnt_r} < nr) ? row_cnt_r : COORD_W'(nr - LEN_W'(1));
    c0 = ({1'b0, col_cnt_r} < nc) ? col_cnt_r : COORD_W'(nc - LEN_W'(1));
    c0_inc = {1'b0, c0} + LEN_W'(1);
    r0_inc = {1'b0, r0} + LEN_W'(1);
    last0 = 1'b0;
    if (c0_inc < nc) begin
      col_cnt_nxt = c0_inc[COORD_W-1:0];
      row_cnt_nxt = r0;
    end else if (r0_inc < nr) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = r0_inc[COORD_W-1:0];
    end else begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      last0       = 1'b1;
    end
  end

  assign stall    = s1_valid_r && s1_last_r && out_valid_r && !out_ready;
  assign in_ready = !stall;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end
      if (!stall) begin
        s1_valid_r <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_pixel;
      s1_last_r <= last0;
      s1_row_r  <= r0;
      s1_col_r  <= c0;
      fwd_sel_r <= s1_fire && (s1_col_r == c0);
      fwd_val_r <= vl;
    end
  end

  lrf_col_mem #(
    .DEPTH (COL_LIM),
    .AW    (COL_AW),
    .DW    (LEN_W)
  ) u_col_mem (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r[COL_AW-1:0]),
    .wr_data (vl),
    .rd_en   (in_fire),
    .rd_addr (c0[COL_AW-1:0]),
    .rd_data (rd_data)
  );

  // run update stage
  always_comb begin
    prev_v = fwd_sel_r ? fwd_val_r : rd_data;
    hl_sum = {1'b0, row_run_r} + (LEN_W+1)'(1);
    vl_sum = {1'b0, prev_v} + (LEN_W+1)'(1);
    if (!s1_px_r) begin
      hl = '0;
    end else if (s1_col_r == '0) begin
      hl = LEN_W'(1);
    end else if (hl_sum > {2'b00, s1_col_r} + (LEN_W+1)'(1)) begin
      hl = {1'b0, s1_col_r} + LEN_W'(1);
    end else begin
      hl = hl_sum[LEN_W-1:0];
    end
    if (!s1_px_r) begin
      vl = '0;
    end else if (s1_row_r == '0) begin
      vl = LEN_W'(1);
    end else if (vl_sum > {2'b00, s1_row_r} + (LEN_W+1)'(1)) begin
      vl = {1'b0, s1_row_r} + LEN_W'(1);
    end else begin
      vl = vl_sum[LEN_W-1:0];
    end
    cand.px  = s1_px_r;
    cand.dir = dir_r;
    cand.hl  = hl;
    cand.vl  = vl;
    cand.row = s1_row_r;
    cand.col = s1_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r <= '0;
    end else if (s1_fire) begin
      row_run_r <= s1_last_r ? '0 : hl;
    end
  end

  lrf_best u_best (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .last   (s1_last_r),
    .cand   (cand),
    .merged (merged)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_run_r <= merged;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = (out_run_r.len != '0);
  assign out_run_length = out_run_r.len;
  assign out_start_row  = out_run_r.sr;
  assign out_start_col  = out_run_r.sc;
  assign out_end_row    = out_run_r.er;
  assign out_end_col    = out_run_r.ec;

endmodule
`default_nettype wire

// ===== rtl/lrf_checker.sv =====
// Port-level checks for the longest line run finder, bound to the top level.
// Depends on lrf_pkg and longest_line_run_finder_unit.
`default_nettype none
module lrf_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_found,
  input wire logic [lrf_pkg::LEN_W-1:0]     out_run_length,
  input wire logic [lrf_pkg::COORD_W-1:0]   out_start_row,
  input wire logic [lrf_pkg::COORD_W-1:0]   out_start_col,
  input wire logic [lrf_pkg::COORD_W-1:0]   out_end_row,
  input wire logic [lrf_pkg::COORD_W-1:0]   out_end_col
);
  import lrf_pkg::*;

  logic [LEN_W-1:0] h_len, v_len;

  assign h_len = {1'b0, out_end_col} - {1'b0, out_start_col} + LEN_W'(1);
  assign v_len = {1'b0, out_end_row} - {1'b0, out_start_row} + LEN_W'(1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_length) &&
      $stable(out_start_row) && $stable(out_start_col) &&
      $stable(out_end_row) && $stable(out_end_col))
    else $error("result changed while stalled");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found == (out_run_length != '0))
    else $error("found does not match run length");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_start_row == '0 && out_start_col == '0 &&
      out_end_row == '0 && out_end_col == '0)
    else $error("empty image reports coordinates");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      (out_start_row == out_end_row && h_len == out_run_length) ||
      (out_start_col == out_end_col && v_len == out_run_length))
    else $error("run endpoints do not match run length");

endmodule

bind longest_line_run_finder_unit lrf_checker u_lrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_found      (out_found),
  .out_run_length (out_run_length),
  .out_start_row  (out_start_row),
  .out_start_col  (out_start_col),
  .out_end_row    (out_end_row),
  .out_end_col    (out_end_col)
);
`default_nettype wire

// ===== verif/longest_line_run_finder_unit_tb.sv =====
// Self-checking testbench for longest_line_run_finder_unit: streams binary images under
// several sizes and both directions and checks each reported longest run against a
// built-in run tracker. Depends on lrf_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module longest_line_run_finder_unit_tb;
  import lrf_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic               found;
    logic [LEN_W-1:0]   len;
    logic [COORD_W-1:0] sr;
    logic [COORD_W-1:0] sc;
    logic [COORD_W-1:0] er;
    logic [COORD_W-1:0] ec;
  } run_rec_t;

  class longest_run_scoreboard;
    logic             dir_reg = DIR_HORIZONTAL;
    logic [LEN_W-1:0] rows_reg = 9'd256;
    logic [LEN_W-1:0] cols_reg = 9'd256;
    int unsigned      row_pos, col_pos, row_run;
    int unsigned      col_runs [256];
    int unsigned      best_len, best_sr, best_sc, best_er, best_ec;
    run_rec_t         expected_runs [$];
    int unsigned      mismatch_count, pixel_count, image_count, hit_count, longest_seen;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      case (idx)
        CFG_DIRECTION: dir_reg = data[0];
        CFG_ROW_COUNT: rows_reg = data;
        CFG_COLUMN_COUNT: cols_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_count(logic [LEN_W-1:0] v);
      if (v == 0) return 1;
      if (v > HW_LIMIT) return HW_LIMIT;
      return 32'(v);
    endfunction

    function void take_run(int unsigned len, int unsigned sr, int unsigned sc,
                           int unsigned er, int unsigned ec);
      best_len = len;
      best_sr = sr;
      best_sc = sc;
      best_er = er;
      best_ec = ec;
    endfunction

    function void note_pixel(logic px);
      int unsigned nr, nc, r, c, hl, vl, sr;
      run_rec_t rec;
      nr = clamp_count(rows_reg);
      nc = clamp_count(cols_reg);
      r = (row_pos < nr) ? row_pos : nr - 1;
      c = (col_pos < nc) ? col_pos : nc - 1;
      pixel_count++;
      if (!px) hl = 0;
      else if (c == 0) hl = 1;
      else hl = row_run + 1;
      if (hl > c + 1) hl = c + 1;
      row_run = hl;
      if (!px) vl = 0;
      else if (r == 0) vl = 1;
      else vl = col_runs[c] + 1;
      if (vl > r + 1) vl = r + 1;
      col_runs[c] = vl;
      sr = r + 1 - vl;
      if (px && dir_reg == DIR_HORIZONTAL && hl > best_len)
        take_run(hl, r, c + 1 - hl, r, c);
      if (px && dir_reg == DIR_VERTICAL && (vl > best_len ||
          (vl == best_len && (c < best_sc || (c == best_sc && sr < best_sr)))))
        take_run(vl, sr, c, r, c);
      if (c + 1 < nc) begin
        col_pos = c + 1;
        row_pos = r;
        return;
      end
      col_pos = 0;
      if (r + 1 < nr) begin
        row_pos = r + 1;
        return;
      end
      rec.found = (best_len != 0);
      rec.len = best_len[LEN_W-1:0];
      rec.sr = best_sr[COORD_W-1:0];
      rec.sc = best_sc[COORD_W-1:0];
      rec.er = best_er[COORD_W-1:0];
      rec.ec = best_ec[COORD_W-1:0];
      expected_runs.push_back(rec);
      row_pos = 0;
      row_run = 0;
      take_run(0, 0, 0, 0, 0);
    endfunction

    function void check_result(run_rec_t got);
      run_rec_t want;
      if (expected_runs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                   got.found, got.len, got.sr, got.sc, got.er, got.ec);
        return;
      end
      want = expected_runs.pop_front();
      image_count++;
      if (want.found) hit_count++;
      if (want.len > longest_seen) longest_seen = 32'(want.len);
      if (got.found !== want.found || got.len !== want.len || got.sr !== want.sr ||
          got.sc !== want.sc || got.er !== want.er || got.ec !== want.ec) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("image %0d expected found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                   image_count, want.found, want.len, want.sr, want.sc, want.er, want.ec);
          $display("image %0d actual   found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                   image_count, got.found, got.len, got.sr, got.sc, got.er, got.ec);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_pixel = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_found;
  logic [LEN_W-1:0]     out_run_length;
  logic [COORD_W-1:0]   out_start_row;
  logic [COORD_W-1:0]   out_start_col;
  logic [COORD_W-1:0]   out_end_row;
  logic [COORD_W-1:0]   out_end_col;

  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          long_hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  longest_run_scoreboard sb = new();

  longest_line_run_finder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel(in_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_found(out_found),
    .out_run_length(out_run_length),
    .out_start_row(out_start_row),
    .out_start_col(out_start_col),
    .out_end_row(out_end_row),
    .out_end_col(out_end_col)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_runs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    run_rec_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        got.found = out_found;
        got.len = out_run_length;
        got.sr = out_start_row;
        got.sc = out_start_col;
        got.er = out_end_row;
        got.ec = out_end_col;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_pixel(in_pixel);
    end
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [LEN_W-1:0] encode_count(int n);
    if (n == 1 && $urandom_range(0, 2) == 0) return '0;
    return n[LEN_W-1:0];
  endfunction

  function automatic int pick_density();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return 0;
    if (m == 1) return 100;
    return $urandom_range(20, 85);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = pick_gap(rx_steady);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_pixel(input logic px);
    int gap;
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_pixel(bits[i]);
  endtask

  task automatic send_image(input int nr, input int nc, input int density);
    repeat (nr * nc) send_pixel($urandom_range(0, 99) < density);
  endtask

  // hold input, drain all results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic dir, input logic [LEN_W-1:0] rows,
                              input logic [LEN_W-1:0] cols, input bit add_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [LEN_W-1:0]     dat [4];
    int                   n, first;
    wait_idle();
    idx[0] = CFG_DIRECTION;
    dat[0] = {8'($urandom_range(0, 255)), dir};
    idx[1] = CFG_ROW_COUNT;
    dat[1] = rows;
    idx[2] = CFG_COLUMN_COUNT;
    dat[2] = cols;
    idx[3] = CFG_SPARE;
    dat[3] = 9'($urandom_range(0, 511));
    n = add_spare ? 4 : 3;
    first = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 3) ? idx[3] : idx[(first + k) % 3];
      cfg_data <= (k == 3) ? dat[3] : dat[(first + k) % 3];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int  phase, big, nr, nc;
    logic dir;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero sizes fold to a single pixel; set then empty
    program_regs(DIR_HORIZONTAL, 9'd0, 9'd0, 1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    // horizontal runs must not join across a row boundary; ties keep the first
    program_regs(DIR_HORIZONTAL, 9'd2, 9'd4, 1'b0);
    send_pattern(32'b1011_1100, 8);
    // vertical tie goes to the lower column even though it appears later in a row
    program_regs(DIR_VERTICAL, 9'd3, 9'd3, 1'b0);
    send_pattern(32'b001_101_100, 9);
    // vertical tie in one column keeps the smaller start row
    program_regs(DIR_VERTICAL, 9'd3, 9'd1, 1'b0);
    send_pattern(32'b101, 3);

    phase = 0;
    big = 0;
    while (sb.pixel_count < 750) begin
      phase++;
      tx_steady = ($urandom_range(0, 2) == 0);
      rx_steady = ($urandom_range(0, 2) == 0);
      if (phase % 3 == 2 && big < 2) begin
        case (big)
          0: begin
            program_regs(DIR_VERTICAL, 9'($urandom_range(257, 511)), 9'd0, 1'b0);
            send_image(256, 1, 100);
          end
          default: begin
            program_regs(DIR_HORIZONTAL, 9'd0, 9'd256, 1'b0);
            send_image(1, 256, 100);
          end
        endcase
        big++;
      end else begin
        dir = 1'($urandom_range(0, 1));
        nr = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        nc = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        program_regs(dir, encode_count(nr), encode_count(nc), $urandom_range(0, 15) == 0);
        repeat ($urandom_range(1, 5)) send_image(nr, nc, pick_density());
      end
    end

    // hold off the receiver while tiny images keep coming, so the input stalls
    program_regs(1'($urandom_range(0, 1)), 9'd1, 9'd2, 1'b0);
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    long_hold_pending = 1'b1;
    repeat (30) send_image(1, 2, 50);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("checked %0d images from %0d pixel transfers, %0d with a run, longest %0d",
             sb.image_count, sb.pixel_count, sb.hit_count, sb.longest_seen);
    $display("both directions, tie order, size folding and a long output stall; %0d mismatches",
             sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
